@@ rtl/ges_pkg.sv @@
// package for the gaussian elimination solver: constants, opcodes, fixed-point helpers
`timescale 1ns / 1ps
`default_nettype none
package ges_pkg;
    localparam int DefMaxSize  = 16;
    localparam int DefFracBits = 16;
    localparam int DataW       = 32;
    localparam int CfgW        = 5;
    localparam int RowW        = 4;

    localparam logic signed [DataW-1:0] SatPos = {1'b0, {(DataW-1){1'b1}}};
    localparam logic signed [DataW-1:0] SatNeg = {1'b1, {(DataW-1){1'b0}}};

    // datapath operation codes
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_LOAD = 3'd1;
    localparam logic [2:0] OP_DIV  = 3'd2;
    localparam logic [2:0] OP_MSUB = 3'd3;
    localparam logic [2:0] OP_ZERO = 3'd4;
    localparam logic [2:0] OP_BSUB = 3'd5;
    localparam logic [2:0] OP_BDIV = 3'd6;
    localparam logic [2:0] OP_BLD  = 3'd7;

    // saturate a wide signed value to 32 bits, flag overflow
    function automatic logic [DataW:0] sat32(input logic signed [65:0] v);
        logic [DataW:0] r;
        if (v > 66'sd2147483647) r = {1'b1, SatPos};
        else if (v < -66'sd2147483648) r = {1'b1, SatNeg};
        else r = {1'b0, v[DataW-1:0]};
        return r;
    endfunction
endpackage
`default_nettype wire

@@ rtl/ges_if.sv @@
// valid/ready channel interfaces for matrix entries and solution items
`timescale 1ns / 1ps
`default_nettype none
interface ges_in_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] matrix_value;
    modport source (output valid, output matrix_value, input ready);
    modport sink   (input valid, input matrix_value, output ready);
endinterface

interface ges_out_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] solution_value;
    logic [3:0]        row_index;
    logic              error_flag;
    logic              last;
    modport source (output valid, output solution_value, output row_index,
                    output error_flag, output last, input ready);
    modport sink   (input valid, input solution_value, input row_index,
                    input error_flag, input last, output ready);
endinterface
`default_nettype wire

@@ rtl/ges_div.sv @@
// iterative restoring divider for signed fixed-point quotients, one bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module ges_div
    import ges_pkg::*;
#(
    parameter int FRAC_BITS = DefFracBits
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire signed [31:0] i_num,
    input  wire signed [31:0] i_den,
    output logic             o_done,
    output logic signed [31:0] o_quot,
    output logic             o_sat
);
    localparam int NumW = 32 + FRAC_BITS + 1;
    localparam int CntW = $clog2(NumW + 1);

    logic            r_busy;
    logic [CntW-1:0] r_cnt;
    logic [NumW-1:0] r_num;
    logic [33:0]     r_den;
    logic [33:0]     r_rem;
    logic [NumW-1:0] r_q;
    logic            r_neg;
    logic            r_done;
    logic signed [31:0] r_quot;
    logic            r_sat;

    logic [33:0]     w_trial;
    logic [33:0]     w_sh;
    logic [32:0]     w_anum;
    logic [32:0]     w_aden;
    logic [NumW:0]   w_qr;
    logic signed [65:0] w_sq;
    logic [DataW:0]  w_s;

    assign w_anum = i_num[31] ? 33'(-34'(i_num)) : {1'b0, i_num};
    assign w_aden = i_den[31] ? 33'(-34'(i_den)) : {1'b0, i_den};
    assign w_sh   = {r_rem[32:0], r_num[NumW-1]};
    assign w_trial = w_sh - r_den;
    // rounded: (2*num/den + 1) / 2 using one extra quotient bit
    assign w_qr   = ({1'b0, r_q} + 1'b1) >> 1;
    assign w_sq   = r_neg ? -66'(signed'({1'b0, w_qr})) : 66'(signed'({1'b0, w_qr}));
    assign w_s    = sat32(w_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_den == '0) begin
                    r_done <= 1'b1;
                    r_quot <= i_num[31] ? SatNeg : SatPos;
                    r_sat  <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CntW'(NumW);
                    r_num  <= NumW'({w_anum, {FRAC_BITS{1'b0}}, 1'b0});
                    r_den  <= {1'b0, w_aden};
                    r_rem  <= '0;
                    r_q    <= '0;
                    r_neg  <= i_num[31] ^ i_den[31];
                end
            end else if (r_busy) begin
                r_num <= r_num << 1;
                if (!w_trial[33]) begin
                    r_rem <= w_trial;
                    r_q   <= {r_q[NumW-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_q   <= {r_q[NumW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) r_busy <= 1'b0;
            end
            if (r_busy && r_cnt == CntW'(0)) begin
                r_done <= 1'b1;
                r_quot <= w_s[DataW-1:0];
                r_sat  <= w_s[DataW];
            end
        end
    end

    // tail cycle after the shift count runs out
    logic r_tail;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tail <= 1'b0;
        else r_tail <= r_busy && r_cnt == CntW'(1);
    end

    always_comb begin
        o_done = r_done;
        o_quot = r_quot;
        o_sat  = r_sat;
        if (r_tail) begin
            o_done = 1'b1;
            o_quot = w_s[DataW-1:0];
            o_sat  = w_s[DataW];
        end
    end
endmodule
`default_nettype wire

@@ rtl/ges_datapath.sv @@
// matrix memory, multiply-subtract pipeline, divider and solution store
`timescale 1ns / 1ps
`default_nettype none
module ges_datapath
    import ges_pkg::*;
#(
    parameter int MAX_SIZE  = DefMaxSize,
    parameter int FRAC_BITS = DefFracBits,
    localparam int AddrW = $clog2(MAX_SIZE * (MAX_SIZE + 1)),
    localparam int IdxW  = $clog2(MAX_SIZE)
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire [2:0]        i_op,
    input  wire [AddrW-1:0]  i_addr_a,
    input  wire [AddrW-1:0]  i_addr_b,
    input  wire [AddrW-1:0]  i_addr_w,
    input  wire [IdxW-1:0]   i_sidx,
    input  wire signed [31:0] i_load,
    input  wire              i_clr_err,
    output logic             o_div_done,
    output logic             o_err,
    output logic signed [31:0] o_sol
);
    logic signed [31:0] r_mem [MAX_SIZE * (MAX_SIZE + 1)];
    logic signed [31:0] r_sol [MAX_SIZE];
    logic signed [31:0] r_rda, r_rdb, r_f, r_acc, r_sold;
    logic        r_err;
    logic [2:0]  r_op1, r_op2;
    logic [AddrW-1:0] r_w1, r_w2;
    logic [IdxW-1:0]  r_s1, r_s2;
    logic signed [65:0] r_prod;
    logic signed [31:0] r_minu;
    logic        r_bdiv;

    logic div_start, div_done, div_sat;
    logic signed [31:0] div_q;
    logic signed [31:0] w_bmul;
    logic signed [31:0] w_num;
    logic signed [63:0] w_p;
    logic [63:0] w_m, w_qm;
    logic signed [65:0] w_pr;
    logic [DataW:0] w_ps, w_dif;

    // stage 1: memory reads (a: minuend/dividend, b: multiplicand/divisor)
    always_ff @(posedge i_clk) begin
        if (i_op == OP_LOAD || i_op == OP_ZERO)
            r_mem[i_addr_w] <= (i_op == OP_LOAD) ? i_load : '0;
        else if (r_op2 == OP_MSUB)
            r_mem[r_w2] <= w_dif[31:0];
        r_rda <= r_mem[i_addr_a];
        r_rdb <= r_mem[i_addr_b];
        r_sold <= r_sol[i_sidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op1 <= OP_NONE;
            r_op2 <= OP_NONE;
        end else begin
            r_op1 <= (i_op == OP_LOAD || i_op == OP_ZERO) ? OP_NONE : i_op;
            r_op2 <= (r_op1 == OP_MSUB || r_op1 == OP_BSUB) ? r_op1 : OP_NONE;
        end
        r_w1 <= i_addr_w;
        r_s1 <= i_sidx;
        r_w2 <= r_w1;
    end

    // stage 2: product of the pivot row entry (or coefficient) and factor (or unknown)
    assign w_bmul = (r_op1 == OP_BSUB) ? r_sold : r_f;
    assign w_p  = r_rdb * w_bmul;
    assign w_m  = w_p[63] ? 64'(-w_p) : 64'(w_p);
    assign w_qm = (w_m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign w_pr = w_p[63] ? -66'(signed'({2'b0, w_qm})) : 66'(signed'({2'b0, w_qm}));
    always_ff @(posedge i_clk) begin
        r_prod <= w_pr;
        // back-to-back subtracts take the running sum straight from stage 3
        if (r_op1 == OP_BSUB)
            r_minu <= (r_op2 == OP_BSUB) ? w_dif[31:0] : r_acc;
        else
            r_minu <= r_rda;
    end

    // stage 3: saturate product, subtract, saturate
    assign w_ps  = sat32(r_prod);
    assign w_dif = sat32(66'(r_minu) - 66'(signed'(w_ps[DataW-1:0])));

    assign div_start = (r_op1 == OP_DIV) || (r_op1 == OP_BDIV);
    assign w_num = (r_op1 == OP_BDIV) ? r_acc : r_rda;

    ges_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk, .i_rst_n, .i_start(div_start), .i_num(w_num), .i_den(r_rdb),
        .o_done(div_done), .o_quot(div_q), .o_sat(div_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
        end else begin
            if (i_clr_err) r_err <= 1'b0;
            else if ((r_op2 != OP_NONE && (w_ps[DataW] || w_dif[DataW]))
                     || (div_done && div_sat)) r_err <= 1'b1;
        end
        if (div_start) r_bdiv <= (r_op1 == OP_BDIV);
        if (div_start) r_s2 <= r_s1;
        // back substitution accumulator starts from the right side entry
        if (r_op2 == OP_BSUB) r_acc <= w_dif[31:0];
        else if (r_op1 == OP_BLD) r_acc <= r_rda;
        if (div_done && !r_bdiv) r_f <= div_q;
        if (div_done && r_bdiv) r_sol[r_s2] <= div_q;
    end

    assign o_div_done = div_done;
    assign o_err      = r_err;
    assign o_sol      = r_sold;
endmodule
`default_nettype wire

@@ rtl/ges_ctrl.sv @@
// sequencer for loading, forward elimination, back substitution and output
`timescale 1ns / 1ps
`default_nettype none
module ges_ctrl
    import ges_pkg::*;
#(
    parameter int MAX_SIZE = DefMaxSize,
    localparam int AddrW = $clog2(MAX_SIZE * (MAX_SIZE + 1)),
    localparam int IdxW  = $clog2(MAX_SIZE),
    localparam int CntW  = $clog2(MAX_SIZE + 1)
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [CfgW-1:0]   i_cfg_data,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output logic [2:0]       o_op,
    output logic [AddrW-1:0] o_addr_a,
    output logic [AddrW-1:0] o_addr_b,
    output logic [AddrW-1:0] o_addr_w,
    output logic [IdxW-1:0]  o_sidx,
    output logic             o_clr_err,
    input  wire              i_div_done,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output logic [RowW-1:0]  o_row,
    output logic             o_last
);
    localparam logic [3:0] S_LOAD = 4'd0, S_FDIV = 4'd1, S_FWAIT = 4'd2,
                           S_FMS = 4'd3, S_FDRAIN = 4'd4, S_BINIT = 4'd5,
                           S_BMS = 4'd6, S_BDRAIN = 4'd7, S_BDIV = 4'd8,
                           S_BWAIT = 4'd9, S_ORD = 4'd10, S_OUT = 4'd11,
                           S_BLD = 4'd12;

    logic [3:0]       r_st;
    logic [CfgW-1:0]  r_size;
    logic [CntW-1:0]  w_n;
    logic [AddrW:0]   r_lc;
    logic [CntW-1:0]  r_k, r_i, r_j;
    logic [1:0]       r_dr;
    logic [AddrW:0]   w_total;

    always_comb begin
        if (r_size == '0) w_n = CntW'(1);
        else if (32'(r_size) > MAX_SIZE) w_n = CntW'(MAX_SIZE);
        else w_n = CntW'(r_size);
    end
    assign w_total = (AddrW+1)'(w_n) * (AddrW+1)'(w_n + 1'b1);

    function automatic logic [AddrW-1:0] adr(input logic [CntW-1:0] r,
                                             input logic [CntW-1:0] c,
                                             input logic [CntW-1:0] n);
        return AddrW'((AddrW+1)'(r) * (AddrW+1)'(n + 1'b1) + (AddrW+1)'(c));
    endfunction

    assign o_in_ready = (r_st == S_LOAD);

    always_comb begin
        o_op = OP_NONE;
        o_addr_a = '0;
        o_addr_b = '0;
        o_addr_w = '0;
        o_sidx = IdxW'(r_j);
        o_clr_err = 1'b0;
        unique case (r_st)
            S_LOAD: begin
                o_addr_w = AddrW'(r_lc);
                if (i_in_valid) o_op = OP_LOAD;
            end
            S_FDIV: begin
                o_op = OP_DIV;
                o_addr_a = adr(r_i, r_k, w_n);
                o_addr_b = adr(r_k, r_k, w_n);
            end
            S_FMS: begin
                o_op = OP_MSUB;
                o_addr_a = adr(r_i, r_j, w_n);
                o_addr_b = adr(r_k, r_j, w_n);
                o_addr_w = adr(r_i, r_j, w_n);
            end
            S_FDRAIN: begin
                // after the last multiply-subtract write has landed
                if (r_dr == 2'd2) begin
                    o_op = OP_ZERO;
                    o_addr_w = adr(r_i, r_k, w_n);
                end
            end
            S_BLD: begin
                o_op = OP_BLD;
                o_addr_a = adr(r_i, w_n, w_n);
            end
            S_BMS: begin
                o_op = OP_BSUB;
                o_addr_b = adr(r_i, r_j, w_n);
            end
            S_BDIV: begin
                o_op = OP_BDIV;
                o_addr_b = adr(r_i, r_i, w_n);
                o_sidx = IdxW'(r_i);
            end
            S_ORD: o_sidx = IdxW'(r_i);
            S_OUT: begin
                o_sidx = IdxW'(r_i);
                if (i_out_ready && r_i == '0) o_clr_err = 1'b1;
            end
            default: ;
        endcase
        if (i_cfg_we) o_clr_err = 1'b1;
    end

    assign o_out_valid = (r_st == S_OUT);
    assign o_row  = RowW'(r_i);
    assign o_last = (r_i == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD;
            r_size <= CfgW'(16);
            r_lc <= '0;
            r_k <= '0; r_i <= '0; r_j <= '0; r_dr <= '0;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_data;
            r_lc <= '0;
            r_st <= S_LOAD;
        end else begin
            unique case (r_st)
                S_LOAD: if (i_in_valid) begin
                    if (r_lc + 1'b1 == w_total) begin
                        r_lc <= '0;
                        r_k <= '0;
                        r_i <= CntW'(1);
                        r_st <= (w_n == CntW'(1)) ? S_BINIT : S_FDIV;
                    end else r_lc <= r_lc + 1'b1;
                end
                S_FDIV: r_st <= S_FWAIT;
                S_FWAIT: if (i_div_done) begin
                    r_j <= r_k + 1'b1;
                    r_st <= S_FMS;
                end
                S_FMS: begin
                    if (r_j == w_n) begin
                        r_dr <= 2'd0;
                        r_st <= S_FDRAIN;
                    end else r_j <= r_j + 1'b1;
                end
                S_FDRAIN: begin
                    r_dr <= r_dr + 1'b1;
                    if (r_dr == 2'd3) begin
                        if (r_i + 1'b1 < w_n) begin
                            r_i <= r_i + 1'b1;
                            r_st <= S_FDIV;
                        end else if (r_k + 2'd2 < w_n) begin
                            r_k <= r_k + 1'b1;
                            r_i <= r_k + 2'd2;
                            r_st <= S_FDIV;
                        end else r_st <= S_BINIT;
                    end
                end
                S_BINIT: begin
                    r_i <= w_n - 1'b1;
                    r_st <= S_BLD;
                end
                S_BLD: begin
                    r_j <= r_i + 1'b1;
                    r_dr <= '0;
                    r_st <= (r_i + 1'b1 < w_n) ? S_BMS : S_BDRAIN;
                end
                S_BMS: begin
                    if (r_j + 1'b1 == w_n) begin
                        r_dr <= '0;
                        r_st <= S_BDRAIN;
                    end
                    r_j <= r_j + 1'b1;
                end
                S_BDRAIN: begin
                    r_dr <= r_dr + 1'b1;
                    if (r_dr == 2'd3) r_st <= S_BDIV;
                end
                S_BDIV: r_st <= S_BWAIT;
                S_BWAIT: if (i_div_done) begin
                    if (r_i == '0) begin
                        r_i <= w_n - 1'b1;
                        r_st <= S_ORD;
                    end else begin
                        r_i <= r_i - 1'b1;
                        r_st <= S_BLD;
                    end
                end
                S_ORD: r_st <= S_OUT;
                S_OUT: if (i_out_ready) begin
                    if (r_i == '0) r_st <= S_LOAD;
                    else begin
                        r_i <= r_i - 1'b1;
                        r_st <= S_ORD;
                    end
                end
                default: r_st <= S_LOAD;
            endcase
        end
    end

    // bsub reads stay one row at a time: product pipeline is drained before divide
    a_in_only_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid) else $error("input and output both open");
    a_last_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_row == '0)) else $error("last on nonzero row");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready && !i_cfg_we) |=> (o_out_valid && $stable(o_row)))
        else $error("output dropped while stalled");
endmodule
`default_nettype wire

@@ rtl/gaussian_elimination_solver.sv @@
// top level of the fixed-point gaussian elimination solver
//  channel   dir   handshake        payload
//  in        in    valid/ready      matrix_value
//  out       out   valid/ready      solution_value, row_index, error_flag, last
//  cfg       in    i_cfg_we         size_in_use (5 bits)
// entries load one a cycle; then each eliminated row runs a serial divide (a zero divisor
// ends it early), a run of multiply-subtracts and a drain of the product pipeline
// back substitution adds a load step per row, then the same; each item out: S_ORD, S_OUT
// reset is synchronous; it restores size 16 and clears the error flag
// a stalled output holds the item; no entry is taken until the run is sent or a size is written
`timescale 1ns / 1ps
`default_nettype none
module gaussian_elimination_solver
    import ges_pkg::*;
#(
    parameter int MAX_SIZE  = DefMaxSize,
    parameter int FRAC_BITS = DefFracBits
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_cfg_we,
    input  wire [CfgW-1:0] i_cfg_data,
    ges_in_if.sink         i_in,
    ges_out_if.source      o_out
);
    localparam int AddrW = $clog2(MAX_SIZE * (MAX_SIZE + 1));
    localparam int IdxW  = $clog2(MAX_SIZE);

    logic [2:0]       op;
    logic [AddrW-1:0] addr_a, addr_b, addr_w;
    logic [IdxW-1:0]  sidx;
    logic             clr_err, div_done, err;
    logic signed [31:0] sol;

    ges_ctrl #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data,
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .o_op(op), .o_addr_a(addr_a), .o_addr_b(addr_b), .o_addr_w(addr_w),
        .o_sidx(sidx), .o_clr_err(clr_err), .i_div_done(div_done),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .o_row(o_out.row_index), .o_last(o_out.last)
    );

    ges_datapath #(.MAX_SIZE(MAX_SIZE), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_op(op), .i_addr_a(addr_a), .i_addr_b(addr_b),
        .i_addr_w(addr_w), .i_sidx(sidx), .i_load(i_in.matrix_value),
        .i_clr_err(clr_err), .o_div_done(div_done), .o_err(err), .o_sol(sol)
    );

    assign o_out.solution_value = sol;
    assign o_out.error_flag     = err;
endmodule
`default_nettype wire
